>>> design/nhd_pkg.sv
package nhd_pkg;

    // Default sizes of the length counters and of the fraction of the result.
    localparam int LENGTH_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // Depth of the queue between the counting front and the dividing back.
    localparam int JOB_DEPTH = 4;

    // Normalization modes.
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_MIN  = 2'd1;
    localparam logic [1:0] MODE_MAX  = 2'd2;
    localparam logic [1:0] MODE_AVG  = 2'd3;

    // Clamp values of the result fields.
    localparam logic [31:0] QUOT_MAX_VAL = 32'hFFFF_FFFF;
    localparam logic [15:0] RAW_MAX_VAL  = 16'hFFFF;

    // One aligned symbol pair.
    typedef struct packed {
        logic [7:0] sym_a;
        logic       sym_a_valid;
        logic [7:0] sym_b;
        logic       sym_b_valid;
        logic       last_pair;
    } t_in_item;

    // One comparison result.
    typedef struct packed {
        logic [15:0] raw_distance;
        logic [31:0] norm_distance;
        logic        zero_divisor;
        logic        length_overflow;
    } t_out_item;

endpackage

>>> design/nhd_front.sv
module nhd_front import nhd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  t_in_item               i_item,
    output logic                   o_job_push,
    output logic [LENGTH_BITS-1:0] o_job_mis,
    output logic [LENGTH_BITS-1:0] o_job_len_a,
    output logic [LENGTH_BITS-1:0] o_job_len_b,
    output logic                   o_job_ovf
);

    logic [LENGTH_BITS-1:0] r_mis, n_mis;
    logic [LENGTH_BITS-1:0] r_len_a, n_len_a;
    logic [LENGTH_BITS-1:0] r_len_b, n_len_b;
    logic                   r_ovf, n_ovf;
    logic                   hit_mis;
    logic                   sat_mis, sat_a, sat_b;

    // Classify the pair and step the saturating counters.
    always_comb begin
        hit_mis = (i_item.sym_a_valid && i_item.sym_b_valid &&
                   (i_item.sym_a != i_item.sym_b)) ||
                  (i_item.sym_a_valid != i_item.sym_b_valid);
        sat_mis = (r_mis == '1);
        sat_a   = (r_len_a == '1);
        sat_b   = (r_len_b == '1);

        n_mis   = (hit_mis && !sat_mis) ? r_mis + LENGTH_BITS'(1) : r_mis;
        n_len_a = (i_item.sym_a_valid && !sat_a) ? r_len_a + LENGTH_BITS'(1) : r_len_a;
        n_len_b = (i_item.sym_b_valid && !sat_b) ? r_len_b + LENGTH_BITS'(1) : r_len_b;
        n_ovf   = r_ovf || (hit_mis && sat_mis) || (i_item.sym_a_valid && sat_a) ||
                  (i_item.sym_b_valid && sat_b);
    end

    // The last pair hands the totals to the back and starts a new comparison.
    assign o_job_push  = i_accept && i_item.last_pair;
    assign o_job_mis   = n_mis;
    assign o_job_len_a = n_len_a;
    assign o_job_len_b = n_len_b;
    assign o_job_ovf   = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mis   <= '0;
            r_len_a <= '0;
            r_len_b <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            if (i_item.last_pair) begin
                r_mis   <= '0;
                r_len_a <= '0;
                r_len_b <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_mis   <= n_mis;
                r_len_a <= n_len_a;
                r_len_b <= n_len_b;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

>>> design/nhd_fifo.sv
module nhd_fifo import nhd_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = JOB_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr_ptr;
    logic [AW:0]      r_rd_ptr;

    // Pointers carry one extra wrap bit to tell full from empty.
    assign o_empty   = (r_wr_ptr == r_rd_ptr);
    assign o_full    = (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]) &&
                       (r_wr_ptr[AW] != r_rd_ptr[AW]);
    assign o_rd_data = r_mem[r_rd_ptr[AW-1:0]];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_wr_data;
        end
    end

    // Pointer update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + (AW+1)'(1);
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + (AW+1)'(1);
            end
        end
    end

endmodule

>>> design/nhd_back.sv
module nhd_back import nhd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_empty,
    input  logic [LENGTH_BITS-1:0] i_job_mis,
    input  logic [LENGTH_BITS-1:0] i_job_len_a,
    input  logic [LENGTH_BITS-1:0] i_job_len_b,
    input  logic                   i_job_ovf,
    input  logic [1:0]             i_job_mode,
    output logic                   o_job_pop,
    output logic                   o_empty,
    input  logic                   i_pop,
    output t_out_item              o_result
);

    // Numerator holds the distance shifted up by the fraction plus one bit for
    // the average mode; the divisor is sized for the sum of both lengths.
    localparam int NW = LENGTH_BITS + FRAC_BITS + 1;
    localparam int DW = LENGTH_BITS + 1;
    localparam int CW = $clog2(NW + 1);
    localparam int EW = NW + 32;
    localparam int RW = LENGTH_BITS + 16;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic          r_zero;
    logic          r_ovf;
    logic [15:0]   r_raw;
    logic          r_out_valid;
    t_out_item     r_result;

    logic [DW-1:0] den_sel;
    logic [NW-1:0] num_sel;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;
    logic [EW-1:0] quo_ext;
    logic [RW-1:0] mis_ext;
    logic          out_free;
    logic          take_job;

    // Divisor and numerator of the job at the head of the queue.
    always_comb begin
        num_sel = NW'({i_job_mis, {FRAC_BITS{1'b0}}});
        case (i_job_mode)
            MODE_MIN: begin
                den_sel = DW'((i_job_len_a < i_job_len_b) ? i_job_len_a : i_job_len_b);
            end
            MODE_MAX: begin
                den_sel = DW'((i_job_len_a > i_job_len_b) ? i_job_len_a : i_job_len_b);
            end
            MODE_AVG: begin
                den_sel = DW'(i_job_len_a) + DW'(i_job_len_b);
                num_sel = {i_job_mis, {FRAC_BITS{1'b0}}, 1'b0};
            end
            default: begin
                den_sel = DW'(1);
            end
        endcase
        mis_ext = RW'(i_job_mis);
    end

    // One restoring division step: one quotient bit a cycle.
    always_comb begin
        shifted = {r_rem, r_num[NW-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = (shifted >= {1'b0, r_den});
        quo_ext = EW'(r_quo);
    end

    assign out_free  = !r_out_valid || i_pop;
    assign take_job  = (r_state == ST_IDLE) && !i_job_empty;
    assign o_job_pop = take_job;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_result;

    // Sequencer of the shared divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (take_job) begin
                        r_state <= (den_sel == '0) ? ST_HOLD : ST_DIV;
                        r_cnt   <= CW'(NW);
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath of the divider; no reset needed.
    always_ff @(posedge i_clk) begin
        if (take_job) begin
            r_num  <= num_sel;
            r_den  <= den_sel;
            r_rem  <= '0;
            r_quo  <= '0;
            r_zero <= (den_sel == '0);
            r_ovf  <= i_job_ovf;
            r_raw  <= (mis_ext > RW'(RAW_MAX_VAL)) ? RAW_MAX_VAL : mis_ext[15:0];
        end else if (r_state == ST_DIV) begin
            r_num <= r_num << 1;
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    // Result register; a finished result waits here for its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_HOLD) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_HOLD) && out_free) begin
            r_result.raw_distance    <= r_raw;
            r_result.zero_divisor    <= r_zero;
            r_result.length_overflow <= r_ovf;
            if (r_zero) begin
                r_result.norm_distance <= '0;
            end else if (quo_ext > EW'(QUOT_MAX_VAL)) begin
                r_result.norm_distance <= QUOT_MAX_VAL;
            end else begin
                r_result.norm_distance <= quo_ext[31:0];
            end
        end
    end

    // A waiting result stays until it is transferred.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> r_out_valid)
        else $error("result dropped without a transfer");

    // A zero divisor always reports a zero quotient.
    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.zero_divisor) |-> (o_result.norm_distance == '0))
        else $error("zero divisor with nonzero quotient");

    // The divider only runs with steps left to do.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt != '0))
        else $error("divider running with no steps left");

    // A taken job always starts the divider, which is then dividing or holding.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> ((r_state == ST_DIV) || (r_state == ST_HOLD)))
        else $error("job taken without starting the divider");

endmodule

>>> design/normalized_hamming_distance.sv
// Channel   | Ports                        | Transfer when
// ----------+------------------------------+-----------------------------
// Pairs in  | push, full, i_item           | push high and full low
// Results   | empty, pop, o_result         | pop high and empty low
// Config    | i_cfg_wr_en, i_cfg_wr_data   | i_cfg_wr_en high
//
// The front takes one symbol pair every cycle while full is low; full rises only while the job
// queue between front and back holds JOB_DEPTH finished comparisons.
// Each comparison is divided in the back by a restoring divider, one quotient
// bit a cycle; a zero divisor skips the division and goes straight to the result.
// Reset is synchronous and active low; it clears counters, queue and mode.
// A result not popped holds the divider, which then fills the job queue.
module normalized_hamming_distance import nhd_pkg::*; #(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_item,
    output logic       empty,
    input  logic       pop,
    output t_out_item  o_result,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data
);

    localparam int JW = 3 * LENGTH_BITS + 3;

    logic [1:0]             r_norm_mode;
    logic                   accept;
    logic                   job_push;
    logic                   job_pop;
    logic                   job_empty;
    logic [LENGTH_BITS-1:0] f_mis, f_len_a, f_len_b;
    logic                   f_ovf;
    logic [JW-1:0]          job_wr;
    logic [JW-1:0]          job_rd;

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_mode <= MODE_NONE;
        end else if (i_cfg_wr_en) begin
            r_norm_mode <= i_cfg_wr_data;
        end
    end

    assign accept = push && !full;

    // Counting front.
    nhd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_job_push (job_push),
        .o_job_mis  (f_mis),
        .o_job_len_a(f_len_a),
        .o_job_len_b(f_len_b),
        .o_job_ovf  (f_ovf)
    );

    // Queue of finished comparisons, each with the mode it runs under.
    assign job_wr = {r_norm_mode, f_ovf, f_len_b, f_len_a, f_mis};

    nhd_fifo #(
        .WIDTH(JW),
        .DEPTH(JOB_DEPTH)
    ) u_jobq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (job_push),
        .i_wr_data(job_wr),
        .i_pop    (job_pop),
        .o_rd_data(job_rd),
        .o_full   (full),
        .o_empty  (job_empty)
    );

    // Dividing back.
    nhd_back #(
        .LENGTH_BITS(LENGTH_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_empty(job_empty),
        .i_job_mis  (job_rd[LENGTH_BITS-1:0]),
        .i_job_len_a(job_rd[2*LENGTH_BITS-1:LENGTH_BITS]),
        .i_job_len_b(job_rd[3*LENGTH_BITS-1:2*LENGTH_BITS]),
        .i_job_ovf  (job_rd[3*LENGTH_BITS]),
        .i_job_mode (job_rd[JW-1:3*LENGTH_BITS+1]),
        .o_job_pop  (job_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (o_result)
    );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import nhd_pkg::*;

    localparam int LEN_W        = LENGTH_BITS_DEF;
    localparam int FRAC_W       = FRAC_BITS_DEF;
    localparam int LATENCY      = LENGTH_BITS_DEF + FRAC_BITS_DEF + 3;
    localparam int DRAIN_CYCLES = 2 * LATENCY;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_PERCENT = 22;
    localparam logic [LEN_W-1:0] LEN_LIMIT = '1;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_in_item   pair_in = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_out_item  result_out;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = MODE_NONE;

    // Both sides insert random idle cycles while this is set.
    bit idle_on = 1'b1;
    // Holds the result side off until the block backs up.
    bit pop_block = 1'b0;

    int pairs_sent = 0;
    int distances_checked = 0;
    int mismatch_errors = 0;
    int cycle_count = 0;

    // Predictor state: mode, running counters and the expected distances.
    logic [1:0]       model_mode = MODE_NONE;
    logic [LEN_W-1:0] model_mismatches = '0;
    logic [LEN_W-1:0] model_len_a = '0;
    logic [LEN_W-1:0] model_len_b = '0;
    bit               model_saturated = 1'b0;
    t_out_item        expected_distances[$];

    normalized_hamming_distance i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_item        (pair_in),
        .empty         (empty),
        .pop           (pop),
        .o_result      (result_out),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Saturating counter step; hitting the limit marks the comparison.
    function automatic logic [LEN_W-1:0] count_up(input logic [LEN_W-1:0] value);
        if (value == LEN_LIMIT) begin
            model_saturated = 1'b1;
            return value;
        end
        return value + LEN_W'(1);
    endfunction

    // Folds one accepted pair into the counters and, on the last pair,
    // queues the expected distance and clears the counters.
    function automatic void accumulate_pair(input t_in_item pair);
        logic [63:0] numer;
        logic [63:0] denom;
        logic [63:0] quot;
        t_out_item   predicted;
        if ((pair.sym_a_valid && pair.sym_b_valid && pair.sym_a != pair.sym_b) ||
            (pair.sym_a_valid != pair.sym_b_valid))
            model_mismatches = count_up(model_mismatches);
        if (pair.sym_a_valid)
            model_len_a = count_up(model_len_a);
        if (pair.sym_b_valid)
            model_len_b = count_up(model_len_b);
        if (!pair.last_pair)
            return;

        numer = 64'(model_mismatches) << FRAC_W;
        case (model_mode)
            MODE_MIN: begin
                denom = 64'((model_len_a < model_len_b) ? model_len_a : model_len_b);
            end
            MODE_MAX: begin
                denom = 64'((model_len_a > model_len_b) ? model_len_a : model_len_b);
            end
            MODE_AVG: begin
                // Average length as a divisor is the same as 2*d / (len_a + len_b).
                numer = numer << 1;
                denom = 64'(model_len_a) + 64'(model_len_b);
            end
            default: begin
                denom = 64'd1;
            end
        endcase

        if (denom == 64'd0) begin
            quot = 64'd0;
        end else begin
            quot = numer / denom;
            if (quot > 64'(QUOT_MAX_VAL))
                quot = 64'(QUOT_MAX_VAL);
        end
        predicted.raw_distance    = (64'(model_mismatches) > 64'(RAW_MAX_VAL)) ?
                                    RAW_MAX_VAL : 16'(model_mismatches);
        predicted.norm_distance   = quot[31:0];
        predicted.zero_divisor    = (denom == 64'd0);
        predicted.length_overflow = model_saturated;
        expected_distances.push_back(predicted);

        model_mismatches = '0;
        model_len_a      = '0;
        model_len_b      = '0;
        model_saturated  = 1'b0;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_errors++;
        end
    endfunction

    // Checks one result transfer against the oldest expected distance.
    function automatic void check_distance(input t_out_item got);
        t_out_item want;
        if (expected_distances.size() == 0) begin
            $error("Result transfer with no comparison pending: raw_distance %0d",
                   got.raw_distance);
            mismatch_errors++;
            return;
        end
        want = expected_distances.pop_front();
        compare_field("raw_distance", 32'(want.raw_distance), 32'(got.raw_distance));
        compare_field("norm_distance", want.norm_distance, got.norm_distance);
        compare_field("zero_divisor", 32'(want.zero_divisor), 32'(got.zero_divisor));
        compare_field("length_overflow", 32'(want.length_overflow),
                      32'(got.length_overflow));
        distances_checked++;
    endfunction

    // Result side: checks each transfer and drives pop for the next edge.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                check_distance(result_out);
            if (pop_block && full)
                pop_block = 1'b0;
            pop <= !pop_block && !(idle_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    function automatic t_in_item make_pair(input logic [7:0] a, input logic a_ok,
                                           input logic [7:0] b, input logic b_ok,
                                           input logic last);
        t_in_item pair;
        pair.sym_a       = a;
        pair.sym_a_valid = a_ok;
        pair.sym_b       = b;
        pair.sym_b_valid = b_ok;
        pair.last_pair   = last;
        return pair;
    endfunction

    // Offers one pair and returns at the edge of its transfer. Push stays
    // high afterwards; an idle pause here or wait_drained lowers it.
    task automatic send_pair(input t_in_item pair);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        pair_in <= pair;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        accumulate_pair(pair);
        pairs_sent++;
    endtask

    // Stops sending until every expected distance has arrived and the
    // divider has had time to finish.
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_distances.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] mode);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge i_clk);
        cfg_wr_en  <= 1'b0;
        model_mode = mode;
    endtask

    // One comparison of two random strings. Most have clean prefixes, some with a
    // one-sided tail; some carry random valid flags on every pair.
    task automatic send_random_comparison(output int pair_count);
        int len_a;
        int len_b;
        int max_len;
        int equal_pct;
        bit noisy;
        t_in_item pair;
        max_len   = ($urandom_range(9) == 0) ? 48 : 8;
        len_a     = $urandom_range(max_len);
        len_b     = ($urandom_range(2) == 0) ? $urandom_range(max_len) : len_a;
        equal_pct = $urandom_range(100);
        noisy     = ($urandom_range(99) < 15);
        pair_count = (len_a > len_b) ? len_a : len_b;
        if (pair_count == 0)
            pair_count = 1;
        for (int i = 0; i < pair_count; i++) begin
            pair.sym_a       = 8'($urandom);
            pair.sym_b       = ($urandom_range(99) < equal_pct) ? pair.sym_a : 8'($urandom);
            pair.sym_a_valid = noisy ? 1'($urandom) : (i < len_a);
            pair.sym_b_valid = noisy ? 1'($urandom) : (i < len_b);
            pair.last_pair   = (i == pair_count - 1);
            send_pair(pair);
        end
    endtask

    // Fixed pairs: extreme symbols, one-sided and empty positions, an empty
    // comparison and one with a single string present.
    task automatic test_directed_cases(input logic [1:0] mode);
        set_mode(mode);
        idle_on = 1'b1;
        send_pair(make_pair(8'h00, 1'b1, 8'hFF, 1'b1, 1'b1));
        send_pair(make_pair(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1));
        send_pair(make_pair(8'h00, 1'b1, 8'h00, 1'b1, 1'b0));
        send_pair(make_pair(8'hA5, 1'b1, 8'h5A, 1'b0, 1'b0));
        send_pair(make_pair(8'h3C, 1'b0, 8'hC3, 1'b1, 1'b0));
        send_pair(make_pair(8'hFF, 1'b0, 8'h00, 1'b0, 1'b0));
        send_pair(make_pair(8'h7E, 1'b1, 8'h7E, 1'b1, 1'b1));
        send_pair(make_pair(8'hFF, 1'b0, 8'hFF, 1'b0, 1'b1));
        send_pair(make_pair(8'h11, 1'b1, 8'h22, 1'b0, 1'b0));
        send_pair(make_pair(8'h33, 1'b1, 8'h44, 1'b0, 1'b1));
    endtask

    // Random comparisons in one mode, with one full drain halfway through.
    task automatic test_random_mode(input logic [1:0] mode, input bit with_idle,
                                    input int pair_budget);
        int sent;
        int count;
        bit paused;
        set_mode(mode);
        idle_on = with_idle;
        sent    = 0;
        paused  = 1'b0;
        while (sent < pair_budget) begin
            if (!paused && sent >= pair_budget / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            send_random_comparison(count);
            sent += count;
        end
    endtask

    // Short comparisons while results are held, so the job queue fills.
    task automatic test_back_pressure();
        set_mode(MODE_MAX);
        idle_on   = 1'b0;
        pop_block = 1'b1;
        for (int i = 0; i < 20; i++)
            send_pair(make_pair(8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                                1'b1));
        pop_block = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases(MODE_MIN);
        test_directed_cases(MODE_AVG);
        test_random_mode(MODE_NONE, 1'b1, 330);
        test_random_mode(MODE_MAX, 1'b0, 330);
        test_random_mode(MODE_MIN, 1'b1, 330);
        test_random_mode(MODE_AVG, 1'b1, 330);
        test_back_pressure();

        idle_on = 1'b1;
        wait_drained();
        $display("Run covered %0d symbol pairs and %0d checked distances in all four modes,",
                 pairs_sent, distances_checked);
        $display("with empty strings, one-sided tails, an idle-free stretch and a full queue.");
        if (mismatch_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
